>>> sv/tpp_pkg.sv
`default_nettype none
package tpp_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_FNAME   = 3'd0;
    localparam logic [2:0] KIND_OPTION  = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_MESSAGE = 3'd3;
    localparam logic [2:0] KIND_SUMMARY = 3'd4;

    // Summary status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SHORT       = 3'd1;
    localparam logic [2:0] ST_BAD_FNAME   = 3'd2;
    localparam logic [2:0] ST_BAD_MODE    = 3'd3;
    localparam logic [2:0] ST_ACK_LEN     = 3'd4;
    localparam logic [2:0] ST_CODE_RANGE  = 3'd5;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd6;

    // Opcodes.
    localparam logic [15:0] OPC_RRQ   = 16'd1;
    localparam logic [15:0] OPC_WRQ   = 16'd2;
    localparam logic [15:0] OPC_DATA  = 16'd3;
    localparam logic [15:0] OPC_ACK   = 16'd4;
    localparam logic [15:0] OPC_ERROR = 16'd5;

    // Keyword table indexes; modes come first, then options.
    localparam logic [2:0] W_NETASCII   = 3'd0;
    localparam logic [2:0] W_OCTET      = 3'd1;
    localparam logic [2:0] W_MAIL       = 3'd2;
    localparam logic [2:0] W_BLKSIZE    = 3'd3;
    localparam logic [2:0] W_TIMEOUT    = 3'd4;
    localparam logic [2:0] W_TSIZE      = 3'd5;
    localparam logic [2:0] W_WINDOWSIZE = 3'd6;
    localparam logic [2:0] W_OPT_BASE   = W_BLKSIZE;

    // Option selector values; OPT_NONE marks an unknown name.
    localparam logic [2:0] OPT_TSIZE = 3'd2;
    localparam logic [2:0] OPT_NONE  = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [1:0]  option_id;
        logic [31:0] option_value;
        logic [15:0] packet_opcode;
        logic [2:0]  status;
        logic [1:0]  transfer_mode;
        logic [15:0] block_or_code;
    } result_t;

    // Everything one byte causes: an optional result and an optional summary.
    typedef struct packed {
        logic    has_main;
        result_t main;
        logic    has_sum;
        result_t sum;
    } record_t;

    function automatic logic [3:0] word_len(input logic [2:0] w);
        logic [3:0] n;
        case (w)
            W_NETASCII:   n = 4'd8;
            W_OCTET:      n = 4'd5;
            W_MAIL:       n = 4'd4;
            W_BLKSIZE:    n = 4'd7;
            W_TIMEOUT:    n = 4'd7;
            W_TSIZE:      n = 4'd5;
            W_WINDOWSIZE: n = 4'd10;
            default:      n = 4'd0;
        endcase
        return n;
    endfunction

    // Character at position i of keyword w, or zero past its end.
    function automatic logic [7:0] word_char(input logic [2:0] w, input logic [3:0] i);
        logic [79:0] s;
        logic [3:0]  n;
        logic [6:0]  bit_pos;
        logic [7:0]  ch;
        case (w)
            W_NETASCII:   s = 80'("netascii");
            W_OCTET:      s = 80'("octet");
            W_MAIL:       s = 80'("mail");
            W_BLKSIZE:    s = 80'("blksize");
            W_TIMEOUT:    s = 80'("timeout");
            W_TSIZE:      s = 80'("tsize");
            W_WINDOWSIZE: s = 80'("windowsize");
            default:      s = '0;
        endcase
        n = word_len(w);
        bit_pos = {n - 4'd1 - i, 3'b000};
        if (i < n)
            ch = s[bit_pos +: 8];
        else
            ch = 8'h00;
        return ch;
    endfunction

    // Lower-case an ASCII letter.
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        if (c >= 8'h41 && c <= 8'h5A)
            r = c + 8'd32;
        else
            r = c;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/tftp_packet_parser_core.sv
`default_nettype none
// TFTP packet parser.
// Input channel (in_valid/in_ready): one datagram byte per item in byte_in,
// with last_byte high on the final byte of the datagram.
// Output channel (out_valid/out_ready): result items; each byte causes zero,
// one or two of them, and last_result marks the final one of a byte.
// Configuration channel (cfg_valid/cfg_ready/cfg_data): writes
// max_error_code; it is always ready.
// The front parser takes one byte per cycle and writes what it produces into
// a small queue of QUEUE_DEPTH entries; a result is registered in the queue
// before it appears on the output. Input throughput is one byte per cycle
// while the queue has room; the output drains one result per cycle while
// out_ready is high. A byte that causes two results (file name, option, data
// or message result plus its summary) leaves the queue once both are taken.
// When the receiver stalls, the queue fills and in_ready drops only once it
// is full. Reset returns the parser to the start of a packet, empties the
// queue and sets max_error_code to 8.
module tftp_packet_parser_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_in,
    input  wire logic        last_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       kind,
    output logic [7:0]       data_byte,
    output logic [1:0]       option_id,
    output logic [31:0]      option_value,
    output logic [15:0]      packet_opcode,
    output logic [2:0]       status,
    output logic [1:0]       transfer_mode,
    output logic [15:0]      block_or_code,
    output logic             last_result
);

    logic [15:0] max_err_reg;
    logic        fire;
    logic        rec_valid;
    logic        q_full, q_empty, q_pop;
    tpp_pkg::record_t rec, head;
    tpp_pkg::result_t res;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign fire      = in_valid && in_ready;

    // Error code limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_err_reg <= 16'd8;
        else if (cfg_valid && cfg_ready)
            max_err_reg <= cfg_data;
    end

    tpp_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .byte_in        (byte_in),
        .last_byte      (last_byte),
        .max_error_code (max_err_reg),
        .rec            (rec),
        .rec_valid      (rec_valid)
    );

    tpp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_valid),
        .push_data (rec),
        .pop       (q_pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    tpp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .out_ready (out_ready),
        .pop       (q_pop),
        .out_valid (out_valid),
        .res       (res),
        .res_last  (last_result)
    );

    assign kind          = res.kind;
    assign data_byte     = res.data_byte;
    assign option_id     = res.option_id;
    assign option_value  = res.option_value;
    assign packet_opcode = res.packet_opcode;
    assign status        = res.status;
    assign transfer_mode = res.transfer_mode;
    assign block_or_code = res.block_or_code;

    // A summary always closes the results of its byte.
    a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == tpp_pkg::KIND_SUMMARY |-> last_result)
        else $error("summary result without last_result");

    // Only summaries carry packet information.
    a_plain_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != tpp_pkg::KIND_SUMMARY |-> status == tpp_pkg::ST_OK
        && packet_opcode == 16'd0 && block_or_code == 16'd0)
        else $error("non-summary result carries summary fields");

    // Only tsize keeps more than 16 value bits.
    a_opt_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == tpp_pkg::KIND_OPTION |-> option_id == 2'd2
        || option_value[31:16] == 16'd0)
        else $error("16-bit option value too wide");

endmodule
`default_nettype wire

>>> sv/tpp_front.sv
`default_nettype none
module tpp_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [7:0]        byte_in,
    input  wire logic              last_byte,
    input  wire logic [15:0]       max_error_code,
    output tpp_pkg::record_t       rec,
    output logic                   rec_valid
);

    typedef enum logic [15:0] {
        PH_OP_HI    = 16'h0001,
        PH_OP_LO    = 16'h0002,
        PH_FNAME    = 16'h0004,
        PH_MODE     = 16'h0008,
        PH_OPT_NAME = 16'h0010,
        PH_OPT_VAL  = 16'h0020,
        PH_BLK_HI   = 16'h0040,
        PH_BLK_LO   = 16'h0080,
        PH_PAYLOAD  = 16'h0100,
        PH_ACK_HI   = 16'h0200,
        PH_ACK_LO   = 16'h0400,
        PH_ACK_DONE = 16'h0800,
        PH_ERR_HI   = 16'h1000,
        PH_ERR_LO   = 16'h2000,
        PH_ERR_MSG  = 16'h4000,
        PH_SKIP     = 16'h8000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] opcode_reg, opcode_next;
    logic [2:0]  pos_reg, pos_next;
    logic        fne_reg, fne_next;
    logic [3:0]  mmatch_reg, mmatch_next;
    logic [2:0]  mlive_reg, mlive_next;
    logic [1:0]  mode_reg, mode_next;
    logic [3:0]  omatch_reg, omatch_next;
    logic [3:0]  olive_reg, olive_next;
    logic [2:0]  osel_reg, osel_next;
    logic [31:0] acc_reg, acc_next;
    logic        digit_reg, digit_next;
    logic        stop_reg, stop_next;
    logic        over_reg, over_next;
    logic [7:0]  hb_reg, hb_next;
    logic [15:0] num_reg, num_next;
    logic [2:0]  status_reg, status_next;

    logic [7:0]  c_fold;
    logic        is_digit;
    logic [35:0] prod;
    logic [35:0] lim;
    logic [2:0]  end_st;

    assign c_fold   = tpp_pkg::fold(byte_in);
    assign is_digit = (byte_in >= 8'h30) && (byte_in <= 8'h39);
    assign lim      = (osel_reg == tpp_pkg::OPT_TSIZE) ? 36'hFFFFFFFF : 36'h7FFFFFFF;

    // Decimal accumulate as shift-and-add: acc * 10 + digit.
    assign prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                + {32'd0, byte_in[3:0] - 4'd0};

    // Per-byte phase step, emitted results and end-of-packet clearing.
    always_comb
    begin
        logic found;
        logic [1:0] msel;
        logic [2:0] osel;
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        pos_next    = pos_reg;
        fne_next    = fne_reg;
        mmatch_next = mmatch_reg;
        mlive_next  = mlive_reg;
        mode_next   = mode_reg;
        omatch_next = omatch_reg;
        olive_next  = olive_reg;
        osel_next   = osel_reg;
        acc_next    = acc_reg;
        digit_next  = digit_reg;
        stop_next   = stop_reg;
        over_next   = over_reg;
        hb_next     = hb_reg;
        num_next    = num_reg;
        status_next = status_reg;
        rec         = '0;
        found       = 1'b0;
        msel        = 2'd0;
        osel        = tpp_pkg::OPT_NONE;
        end_st      = tpp_pkg::ST_SHORT;

        if (phase_reg == PH_FNAME && pos_reg == 3'd2 && last_byte)
        begin
            // A request of exactly three bytes is too short.
            phase_next  = PH_SKIP;
            status_next = tpp_pkg::ST_SHORT;
        end
        else
        begin
            unique case (phase_reg)
                PH_OP_HI:
                begin
                    hb_next    = byte_in;
                    phase_next = PH_OP_LO;
                end
                PH_OP_LO:
                begin
                    opcode_next = {hb_reg, byte_in};
                    fne_next    = 1'b0;
                    if (opcode_next == tpp_pkg::OPC_RRQ || opcode_next == tpp_pkg::OPC_WRQ)
                        phase_next = PH_FNAME;
                    else if (opcode_next == tpp_pkg::OPC_DATA)
                        phase_next = PH_BLK_HI;
                    else if (opcode_next == tpp_pkg::OPC_ACK)
                        phase_next = PH_ACK_HI;
                    else if (opcode_next == tpp_pkg::OPC_ERROR)
                        phase_next = PH_ERR_HI;
                    else
                    begin
                        phase_next  = PH_SKIP;
                        status_next = tpp_pkg::ST_UNSUPPORTED;
                    end
                end
                PH_FNAME:
                begin
                    if (byte_in != 8'h00)
                    begin
                        rec.has_main       = 1'b1;
                        rec.main.kind      = tpp_pkg::KIND_FNAME;
                        rec.main.data_byte = byte_in;
                        fne_next           = 1'b1;
                    end
                    else if (!fne_reg)
                    begin
                        phase_next  = PH_SKIP;
                        status_next = tpp_pkg::ST_BAD_FNAME;
                    end
                    else
                    begin
                        phase_next  = PH_MODE;
                        mmatch_next = 4'd0;
                        mlive_next  = 3'b111;
                    end
                end
                PH_MODE:
                begin
                    if (byte_in != 8'h00)
                    begin
                        for (int k = 0; k < 3; k++)
                            mlive_next[k] = mlive_reg[k]
                                && (tpp_pkg::word_char(3'(k), mmatch_reg) == c_fold);
                        if (mmatch_reg != 4'd15)
                            mmatch_next = mmatch_reg + 4'd1;
                    end
                    else
                    begin
                        for (int k = 0; k < 3; k++)
                            if (!found && mlive_reg[k]
                                && tpp_pkg::word_len(3'(k)) == mmatch_reg)
                            begin
                                found = 1'b1;
                                msel  = 2'(k);
                            end
                        if (found)
                        begin
                            mode_next   = msel;
                            phase_next  = PH_OPT_NAME;
                            omatch_next = 4'd0;
                            olive_next  = 4'b1111;
                        end
                        else
                        begin
                            phase_next  = PH_SKIP;
                            status_next = tpp_pkg::ST_BAD_MODE;
                        end
                    end
                end
                PH_OPT_NAME:
                begin
                    if (byte_in != 8'h00)
                    begin
                        for (int k = 0; k < 4; k++)
                            olive_next[k] = olive_reg[k]
                                && (tpp_pkg::word_char(tpp_pkg::W_OPT_BASE + 3'(k), omatch_reg)
                                    == c_fold);
                        if (omatch_reg != 4'd15)
                            omatch_next = omatch_reg + 4'd1;
                    end
                    else
                    begin
                        for (int k = 0; k < 4; k++)
                            if (!found && olive_reg[k]
                                && tpp_pkg::word_len(tpp_pkg::W_OPT_BASE + 3'(k)) == omatch_reg)
                            begin
                                found = 1'b1;
                                osel  = 3'(k);
                            end
                        osel_next  = osel;
                        phase_next = PH_OPT_VAL;
                        acc_next   = '0;
                        digit_next = 1'b0;
                        stop_next  = 1'b0;
                        over_next  = 1'b0;
                    end
                end
                PH_OPT_VAL:
                begin
                    if (byte_in != 8'h00)
                    begin
                        if (!stop_reg)
                        begin
                            if (is_digit)
                            begin
                                digit_next = 1'b1;
                                if (!over_reg)
                                begin
                                    acc_next = prod[31:0];
                                    if (prod > lim)
                                        over_next = 1'b1;
                                end
                            end
                            else
                                stop_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (osel_reg != tpp_pkg::OPT_NONE && digit_reg && !over_reg)
                        begin
                            rec.has_main          = 1'b1;
                            rec.main.kind         = tpp_pkg::KIND_OPTION;
                            rec.main.option_id    = osel_reg[1:0];
                            rec.main.option_value = acc_reg;
                            if (osel_reg != tpp_pkg::OPT_TSIZE)
                                rec.main.option_value[31:16] = 16'd0;
                        end
                        phase_next  = PH_OPT_NAME;
                        omatch_next = 4'd0;
                        olive_next  = 4'b1111;
                    end
                end
                PH_BLK_HI:
                begin
                    hb_next    = byte_in;
                    phase_next = PH_BLK_LO;
                end
                PH_ACK_HI:
                begin
                    hb_next    = byte_in;
                    phase_next = PH_ACK_LO;
                end
                PH_ERR_HI:
                begin
                    hb_next    = byte_in;
                    phase_next = PH_ERR_LO;
                end
                PH_BLK_LO:
                begin
                    num_next   = {hb_reg, byte_in};
                    fne_next   = 1'b0;
                    phase_next = PH_PAYLOAD;
                end
                PH_ACK_LO:
                begin
                    num_next   = {hb_reg, byte_in};
                    fne_next   = 1'b0;
                    phase_next = PH_ACK_DONE;
                end
                PH_ERR_LO:
                begin
                    num_next   = {hb_reg, byte_in};
                    fne_next   = 1'b0;
                    phase_next = PH_ERR_MSG;
                end
                PH_PAYLOAD:
                begin
                    rec.has_main       = 1'b1;
                    rec.main.kind      = tpp_pkg::KIND_PAYLOAD;
                    rec.main.data_byte = byte_in;
                end
                PH_ACK_DONE:
                begin
                    phase_next  = PH_SKIP;
                    status_next = tpp_pkg::ST_ACK_LEN;
                end
                PH_ERR_MSG:
                begin
                    if (!fne_reg && num_reg > max_error_code)
                    begin
                        phase_next  = PH_SKIP;
                        status_next = tpp_pkg::ST_CODE_RANGE;
                    end
                    else if (byte_in == 8'h00)
                    begin
                        phase_next  = PH_SKIP;
                        status_next = tpp_pkg::ST_OK;
                    end
                    else
                    begin
                        rec.has_main       = 1'b1;
                        rec.main.kind      = tpp_pkg::KIND_MESSAGE;
                        rec.main.data_byte = byte_in;
                        fne_next           = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Final status from where the packet stopped.
        unique case (phase_next)
            PH_FNAME:    end_st = fne_next ? tpp_pkg::ST_BAD_FNAME : tpp_pkg::ST_SHORT;
            PH_MODE:     end_st = tpp_pkg::ST_BAD_MODE;
            PH_OPT_NAME, PH_OPT_VAL, PH_PAYLOAD, PH_ACK_DONE:
                         end_st = tpp_pkg::ST_OK;
            PH_ACK_HI, PH_ACK_LO:
                         end_st = tpp_pkg::ST_ACK_LEN;
            PH_ERR_MSG:  end_st = fne_next ? tpp_pkg::ST_OK : tpp_pkg::ST_SHORT;
            PH_SKIP:     end_st = status_next;
            default:     end_st = tpp_pkg::ST_SHORT;
        endcase

        if (last_byte)
        begin
            rec.has_sum           = 1'b1;
            rec.sum.kind          = tpp_pkg::KIND_SUMMARY;
            rec.sum.packet_opcode = opcode_next;
            rec.sum.status        = end_st;
            if (end_st == tpp_pkg::ST_OK
                && (opcode_next == tpp_pkg::OPC_RRQ || opcode_next == tpp_pkg::OPC_WRQ))
                rec.sum.transfer_mode = mode_next;
            if (end_st == tpp_pkg::ST_OK && opcode_next >= tpp_pkg::OPC_DATA
                && opcode_next <= tpp_pkg::OPC_ERROR)
                rec.sum.block_or_code = num_next;

            // Start the next packet from a clean state.
            phase_next  = PH_OP_HI;
            opcode_next = '0;
            pos_next    = '0;
            fne_next    = 1'b0;
            mmatch_next = '0;
            mlive_next  = '0;
            mode_next   = '0;
            omatch_next = '0;
            olive_next  = '0;
            osel_next   = '0;
            acc_next    = '0;
            digit_next  = 1'b0;
            stop_next   = 1'b0;
            over_next   = 1'b0;
            hb_next     = '0;
            num_next    = '0;
            status_next = '0;
        end
        else if (pos_reg != 3'd7)
            pos_next = pos_reg + 3'd1;
    end

    assign rec_valid = fire && (rec.has_main || rec.has_sum);

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OP_HI;
            opcode_reg <= '0;
            pos_reg    <= '0;
            fne_reg    <= 1'b0;
            mmatch_reg <= '0;
            mlive_reg  <= '0;
            mode_reg   <= '0;
            omatch_reg <= '0;
            olive_reg  <= '0;
            osel_reg   <= '0;
            acc_reg    <= '0;
            digit_reg  <= 1'b0;
            stop_reg   <= 1'b0;
            over_reg   <= 1'b0;
            hb_reg     <= '0;
            num_reg    <= '0;
            status_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            pos_reg    <= pos_next;
            fne_reg    <= fne_next;
            mmatch_reg <= mmatch_next;
            mlive_reg  <= mlive_next;
            mode_reg   <= mode_next;
            omatch_reg <= omatch_next;
            olive_reg  <= olive_next;
            osel_reg   <= osel_next;
            acc_reg    <= acc_next;
            digit_reg  <= digit_next;
            stop_reg   <= stop_next;
            over_reg   <= over_next;
            hb_reg     <= hb_next;
            num_reg    <= num_next;
            status_reg <= status_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/tpp_queue.sv
`default_nettype none
module tpp_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  tpp_pkg::record_t       push_data,
    input  wire logic              pop,
    output tpp_pkg::record_t       head,
    output logic                   full,
    output logic                   empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tpp_pkg::record_t mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

>>> sv/tpp_back.sv
`default_nettype none
module tpp_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  tpp_pkg::record_t       head,
    input  wire logic              empty,
    input  wire logic              out_ready,
    output logic                   pop,
    output logic                   out_valid,
    output tpp_pkg::result_t       res,
    output logic                   res_last
);

    logic sent_main_reg, sent_main_next;
    logic show_main;
    logic take;

    // Show the main result first, then the summary of the same byte.
    assign show_main = head.has_main && !sent_main_reg;
    assign res       = show_main ? head.main : head.sum;
    assign res_last  = show_main ? !head.has_sum : 1'b1;
    assign out_valid = !empty;
    assign take      = out_valid && out_ready;
    assign pop       = take && res_last;

    always_comb
    begin
        sent_main_next = sent_main_reg;
        if (pop)
            sent_main_next = 1'b0;
        else if (take)
            sent_main_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sent_main_reg <= 1'b0;
        else
            sent_main_reg <= sent_main_next;
    end

endmodule
`default_nettype wire
